FILE: rtl/chebyshev_series_evaluator_macros.svh
// Assertion helpers shared by the checker.
`ifndef CHEBYSHEV_SERIES_EVALUATOR_MACROS_SVH
`define CHEBYSHEV_SERIES_EVALUATOR_MACROS_SVH

// Property checked while out of reset.
`define CSE_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("cse check failed");

// Property checked on every edge, reset included.
`define CSE_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("cse check failed");

`endif

FILE: rtl/cse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cse_pkg;

   localparam int DATA_W  = 32;
   localparam int IDX_W   = 5;
   localparam int COUNT_W = 6;
   localparam int ADDR_W  = 4;
   localparam int QDEPTH  = 4;
   localparam int QPTR_W  = 2;
   localparam int QCNT_W  = 3;

   localparam logic [COUNT_W-1:0]       COUNT_RESET  = 6'd1;
   localparam logic signed [DATA_W-1:0] SCALE_RESET  = 32'sd16777216;
   localparam logic signed [DATA_W-1:0] OFFSET_RESET = 32'sd0;

   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_EVAL = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      REG_COEF_COUNT = 2'd0,
      REG_MAP_SCALE  = 2'd1,
      REG_MAP_OFFSET = 2'd2
   } reg_idx_type;

   typedef struct packed {
      cmd_type           cmd;
      logic [IDX_W-1:0]  index;
      logic [DATA_W-1:0] data;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

   typedef struct packed {
      logic [COUNT_W-1:0]       count;
      logic signed [DATA_W-1:0] scale;
      logic signed [DATA_W-1:0] offset;
   } cfg_type;

endpackage

`default_nettype wire

FILE: rtl/cse_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module cse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/cse_front.sv
`timescale 1ns / 1ps
`default_nettype none

module cse_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_cmd,
   input  logic [cse_pkg::IDX_W-1:0]          req_coef_index,
   input  logic signed [cse_pkg::DATA_W-1:0]  req_coef_value,
   input  logic signed [cse_pkg::DATA_W-1:0]  req_point,
   input  logic                               pop,
   output cse_pkg::head_type                  head
);

   import cse_pkg::*;

   item_type          entries_ff [QDEPTH];
   item_type          item_in;
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              push;
   logic              do_pop;

   assign req_stall = (count_ff == QCNT_W'(QDEPTH));
   assign push      = req_valid && !req_stall;
   assign do_pop    = pop && (count_ff != '0);

   // a load carries its coefficient, an evaluate its point
   always_comb begin
      item_in.cmd   = cmd_type'(req_cmd);
      item_in.index = req_coef_index;
      item_in.data  = (cmd_type'(req_cmd) == CMD_EVAL) ? req_point : req_coef_value;
   end

   assign wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
   assign rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
   assign count_in  = count_ff + QCNT_W'(push) - QCNT_W'(do_pop);

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.item  = entries_ff[rd_ptr_ff];

endmodule

`default_nettype wire

FILE: rtl/cse_back.sv
`timescale 1ns / 1ps
`default_nettype none

module cse_back #(
   parameter int MAX_COEFFS = 32,
   parameter int FRAC_BITS  = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   input  cse_pkg::cfg_type                  cfg,
   input  cse_pkg::head_type                 head,
   output logic                              pop,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [cse_pkg::DATA_W-1:0] rsp_series_value,
   output logic                              rsp_saturated
);

   import cse_pkg::*;

   localparam int AW  = $clog2(MAX_COEFFS);
   localparam int CW  = (AW + 1 > COUNT_W) ? AW + 1 : COUNT_W;
   localparam int ACC_W = 66;
   localparam logic signed [ACC_W-1:0] ACC_MAX = 66'sd2147483647;
   localparam logic signed [ACC_W-1:0] ACC_MIN = -66'sd2147483648;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_MAP  = 5'b00010,
      S_UADD = 5'b00100,
      S_MUL  = 5'b01000,
      S_ACC  = 5'b10000
   } state_type;

   state_type                state_ff, state_in;
   logic [AW-1:0]            k_ff, k_in;
   logic signed [DATA_W-1:0] point_ff, point_in;
   logic signed [63:0]       prod_ff, prod_in;
   logic signed [DATA_W-1:0] u_ff, u_in;
   logic signed [DATA_W-1:0] b1_ff, b1_in;
   logic signed [DATA_W-1:0] b2_ff, b2_in;
   logic                     flag_ff, flag_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic                     rsp_sat_ff, rsp_sat_in;

   logic [CW-1:0]            count_wide;
   logic [AW-1:0]            last_k;
   logic signed [DATA_W-1:0] mul_a, mul_b;
   logic signed [63:0]       m;
   logic signed [ACC_W-1:0]  m_term;
   logic signed [DATA_W-1:0] sum_base, sub;
   logic signed [ACC_W-1:0]  acc;
   logic                     sat_hi, sat_lo, sat_flag;
   logic signed [DATA_W-1:0] sat_val;
   logic [DATA_W-1:0]        rd_data;
   logic                     ram_we;
   logic                     load_ok;
   logic                     out_free;

   cse_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MAX_COEFFS)
   ) u_coef_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (AW'(head.item.index)),
      .wr_data (head.item.data),
      .rd_addr (k_ff),
      .rd_data (rd_data)
   );

   // zero count acts as one, counts past the table are clipped
   assign count_wide = CW'(cfg.count);
   always_comb begin
      if (count_wide == '0) begin
         last_k = '0;
      end else if (count_wide > CW'(MAX_COEFFS)) begin
         last_k = AW'(MAX_COEFFS - 1);
      end else begin
         last_k = AW'(count_wide - CW'(1));
      end
   end

   assign load_ok = (32'(head.item.index) < MAX_COEFFS);

   assign mul_a   = (state_ff == S_MAP) ? cfg.scale : u_ff;
   assign mul_b   = (state_ff == S_MAP) ? point_ff : b1_ff;
   assign prod_in = 64'(mul_a) * 64'(mul_b);

   // floor division by 2^F
   assign m = prod_ff >>> FRAC_BITS;

   always_comb begin
      sum_base = (state_ff == S_UADD) ? cfg.offset : signed'(rd_data);
      sub      = (state_ff == S_ACC) ? b2_ff : '0;
      if ((state_ff == S_ACC) && (k_ff != '0)) begin
         m_term = ACC_W'(m) <<< 1;
      end else begin
         m_term = ACC_W'(m);
      end
      acc      = ACC_W'(sum_base) + m_term - ACC_W'(sub);
      sat_hi   = (acc > ACC_MAX);
      sat_lo   = (acc < ACC_MIN);
      sat_flag = sat_hi || sat_lo;
      if (sat_hi) begin
         sat_val = 32'sh7fffffff;
      end else if (sat_lo) begin
         sat_val = 32'sh80000000;
      end else begin
         sat_val = acc[DATA_W-1:0];
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      point_in     = point_ff;
      u_in         = u_ff;
      b1_in        = b1_ff;
      b2_in        = b2_ff;
      flag_in      = flag_ff;
      rsp_value_in = rsp_value_ff;
      rsp_sat_in   = rsp_sat_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      pop          = 1'b0;
      ram_we       = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (head.valid) begin
               pop = 1'b1;
               if (head.item.cmd == CMD_EVAL) begin
                  point_in = head.item.data;
                  k_in     = last_k;
                  state_in = S_MAP;
               end else begin
                  ram_we = load_ok;
               end
            end
         end
         S_MAP: begin
            state_in = S_UADD;
         end
         S_UADD: begin
            u_in     = sat_val;
            flag_in  = sat_flag;
            b1_in    = '0;
            b2_in    = '0;
            state_in = S_MUL;
         end
         S_MUL: begin
            state_in = S_ACC;
         end
         S_ACC: begin
            if (k_ff != '0) begin
               b1_in    = sat_val;
               b2_in    = b1_ff;
               flag_in  = flag_ff || sat_flag;
               k_in     = k_ff - AW'(1);
               state_in = S_MUL;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = sat_val;
               rsp_sat_in   = flag_ff || sat_flag;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == S_MAP) || (state_ff == S_MUL)) begin
         prod_ff <= prod_in;
      end
      k_ff         <= k_in;
      point_ff     <= point_in;
      u_ff         <= u_in;
      b1_ff        <= b1_in;
      b2_ff        <= b2_in;
      flag_ff      <= flag_in;
      rsp_value_ff <= rsp_value_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_series_value = rsp_value_ff;
   assign rsp_saturated    = rsp_sat_ff;

endmodule

`default_nettype wire

FILE: rtl/chebyshev_series_evaluator.sv
`timescale 1ns / 1ps
`default_nettype none

// Chebyshev series evaluator, Clenshaw recurrence in signed Q8.24.
// req_ channel: cmd 0 loads coef_value into table entry coef_index (one per
// cycle while the engine is idle), cmd 1 evaluates the series at point. A
// transfer happens when req_valid is high and req_stall is low; a four-entry
// queue sits behind it. rsp_ channel: one result per evaluate, held in an
// output register until a transfer with rsp_stall low. Loads give no
// result. An evaluate passes the queue, two steps to map the point, then
// for each coefficient the single 32x32 multiplier and the accumulate and
// clamp step that follows it; one evaluate ends before the next starts.
// While a result waits under stall the engine keeps taking loads and
// evaluates; it holds only when it has a second result ready. Configuration
// (coef_count, map_scale, map_offset at 0x0, 0x4, 0x8) is written over the
// APB port; the user must write it only while the block is idle, which the
// block itself does not enforce. Synchronous reset empties the queue, drops
// any pending result and restores the registers; the coefficient table keeps
// no reset value and must be loaded.

module chebyshev_series_evaluator #(
   parameter int MAX_COEFFS = 32,
   parameter int FRAC_BITS  = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_cmd,
   input  logic [cse_pkg::IDX_W-1:0]         req_coef_index,
   input  logic signed [cse_pkg::DATA_W-1:0] req_coef_value,
   input  logic signed [cse_pkg::DATA_W-1:0] req_point,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [cse_pkg::DATA_W-1:0] rsp_series_value,
   output logic                              rsp_saturated,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [cse_pkg::ADDR_W-1:0]        paddr,
   input  logic [cse_pkg::DATA_W-1:0]        pwdata,
   output logic [cse_pkg::DATA_W-1:0]        prdata,
   output logic                              pready
);

   import cse_pkg::*;

   // unit scale at the configured fraction width
   localparam logic signed [DATA_W-1:0] SCALE_ONE = DATA_W'(1) << FRAC_BITS;

   logic [COUNT_W-1:0]       count_ff, count_in;
   logic signed [DATA_W-1:0] scale_ff, scale_in;
   logic signed [DATA_W-1:0] offset_ff, offset_in;
   logic                     csr_wr;
   reg_idx_type              reg_idx;
   cfg_type                  cfg;
   head_type                 head;
   logic                     pop;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign reg_idx = reg_idx_type'(paddr[ADDR_W-1:2]);

   always_comb begin
      count_in  = count_ff;
      scale_in  = scale_ff;
      offset_in = offset_ff;
      prdata    = '0;
      case (reg_idx)
         REG_COEF_COUNT: begin
            prdata = DATA_W'(count_ff);
            if (csr_wr) begin
               count_in = pwdata[COUNT_W-1:0];
            end
         end
         REG_MAP_SCALE: begin
            prdata = scale_ff;
            if (csr_wr) begin
               scale_in = pwdata;
            end
         end
         REG_MAP_OFFSET: begin
            prdata = offset_ff;
            if (csr_wr) begin
               offset_in = pwdata;
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= COUNT_RESET;
         scale_ff  <= SCALE_ONE;
         offset_ff <= OFFSET_RESET;
      end else begin
         count_ff  <= count_in;
         scale_ff  <= scale_in;
         offset_ff <= offset_in;
      end
   end

   assign cfg.count  = count_ff;
   assign cfg.scale  = scale_ff;
   assign cfg.offset = offset_ff;

   cse_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_coef_index (req_coef_index),
      .req_coef_value (req_coef_value),
      .req_point      (req_point),
      .pop            (pop),
      .head           (head)
   );

   cse_back #(
      .MAX_COEFFS (MAX_COEFFS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .head             (head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_series_value (rsp_series_value),
      .rsp_saturated    (rsp_saturated)
   );

endmodule

`default_nettype wire

FILE: rtl/cse_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "chebyshev_series_evaluator_macros.svh"

module cse_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_stall,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_stall,
   input wire logic signed [cse_pkg::DATA_W-1:0] rsp_series_value,
   input wire logic                              rsp_saturated,
   input wire logic                              psel,
   input wire logic                              penable,
   input wire logic                              pwrite,
   input wire logic [cse_pkg::ADDR_W-1:0]        paddr,
   input wire logic [cse_pkg::DATA_W-1:0]        pwdata,
   input wire logic [cse_pkg::DATA_W-1:0]        prdata,
   input wire logic                              pready
);

   import cse_pkg::*;

   logic              scale_sel;
   logic              scale_wr;
   logic              rsp_wait;
   logic [DATA_W:0]   rsp_payload;

   assign scale_sel   = (paddr[ADDR_W-1:2] == REG_MAP_SCALE);
   assign scale_wr    = psel && penable && pwrite && pready && scale_sel;
   assign rsp_wait    = rsp_valid && rsp_stall;
   assign rsp_payload = {rsp_series_value, rsp_saturated};

   // stalled result holds
   `CSE_ASSERT(a_rsp_hold, clock, reset, rsp_wait |=> (rsp_valid && $stable(rsp_payload)))

   // reset leaves no result pending and the queue open
   `CSE_ASSERT_ALWAYS(a_reset_empty, clock, (!reset && $past(reset)) |-> (!rsp_valid && !req_stall))

   // a scale write reads back on the next cycle
   `CSE_ASSERT(a_scale_readback, clock, reset, scale_wr |=> (!scale_sel || prdata == $past(pwdata)))

endmodule

bind chebyshev_series_evaluator cse_checker u_checker (.*);

`default_nettype wire

FILE: test/tb_chebyshev_series_evaluator.sv
`timescale 1ns / 1ps

module tb_chebyshev_series_evaluator;
   import cse_pkg::*;

   localparam int MAX_COEFFS   = 32;
   localparam int FRAC_BITS    = 24;
   localparam int SETTLE       = 2 * MAX_COEFFS + 16;
   localparam int LONG_HOLD    = 300;
   localparam int PHASE_ITEMS  = 115;
   localparam logic [1:0] REG_UNUSED = 2'd3;
   localparam longint SAT_MAX  = 64'sd2147483647;
   localparam longint SAT_MIN  = -64'sd2147483648;

   typedef struct {
      logic signed [DATA_W-1:0] value;
      logic                     sat;
   } series_result_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic                     req_cmd = CMD_LOAD;
   logic [IDX_W-1:0]         req_coef_index = '0;
   logic signed [DATA_W-1:0] req_coef_value = '0;
   logic signed [DATA_W-1:0] req_point = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [DATA_W-1:0] rsp_series_value;
   logic                     rsp_saturated;
   logic                     psel = 1'b0;
   logic                     penable = 1'b0;
   logic                     pwrite = 1'b0;
   logic [ADDR_W-1:0]        paddr = '0;
   logic [DATA_W-1:0]        pwdata = '0;
   logic [DATA_W-1:0]        prdata;
   logic                     pready;

   // predictor state
   logic signed [DATA_W-1:0] coef_table [MAX_COEFFS];
   logic [COUNT_W-1:0]       cfg_count  = COUNT_RESET;
   logic signed [DATA_W-1:0] cfg_scale  = SCALE_RESET;
   logic signed [DATA_W-1:0] cfg_offset = OFFSET_RESET;

   series_result_type expected_results [$];
   int unsigned    fail_count = 0;
   bit             sender_idles = 1'b1;
   bit             receiver_idles = 1'b1;
   int unsigned    holds_asked = 0;
   int unsigned    holds_served = 0;
   int unsigned    stall_left = 0;

   chebyshev_series_evaluator uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_cmd(req_cmd),
      .req_coef_index(req_coef_index),
      .req_coef_value(req_coef_value),
      .req_point(req_point),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_series_value(rsp_series_value),
      .rsp_saturated(rsp_saturated),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always #2 clock = ~clock;

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic longint clamp32(longint v, inout bit sat);
      if (v > SAT_MAX) begin
         sat = 1'b1;
         return SAT_MAX;
      end
      if (v < SAT_MIN) begin
         sat = 1'b1;
         return SAT_MIN;
      end
      return v;
   endfunction

   // floor(a*b / 2^F): arithmetic shift of the exact product
   function automatic longint fixed_mul(longint a, longint b);
      return (a * b) >>> FRAC_BITS;
   endfunction

   function automatic series_result_type evaluate_series(logic signed [DATA_W-1:0] x);
      series_result_type res;
      bit             sat;
      int             n;
      longint         u, b1, b2, bk, acc;
      sat = 1'b0;
      n = int'(cfg_count);
      if (n < 1) n = 1;
      if (n > MAX_COEFFS) n = MAX_COEFFS;
      u = clamp32(fixed_mul(longint'(cfg_scale), longint'(x)) + longint'(cfg_offset), sat);
      b1 = 0;
      b2 = 0;
      for (int k = n - 1; k >= 1; k--) begin
         bk = clamp32(longint'(coef_table[k]) + 2 * fixed_mul(u, b1) - b2, sat);
         b2 = b1;
         b1 = bk;
      end
      acc = clamp32(longint'(coef_table[0]) + fixed_mul(u, b1) - b2, sat);
      res.value = acc[DATA_W-1:0];
      res.sat = sat;
      return res;
   endfunction

   // result side: random stall, long hold on request
   always @(posedge clock) begin
      if (holds_served != holds_asked) begin
         holds_served = holds_asked;
         rsp_stall <= 1'b1;
         stall_left = LONG_HOLD;
      end else if (stall_left != 0) begin
         stall_left--;
      end else if (!receiver_idles || $urandom_range(0, 2) != 0) begin
         rsp_stall <= 1'b0;
         stall_left = receiver_idles ? $urandom_range(0, 6) : 0;
      end else begin
         rsp_stall <= 1'b1;
         stall_left = pick_gap();
      end
   end

   always @(posedge clock) begin
      series_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected transfer, series_value %h saturated %b", $time,
                     rsp_series_value, rsp_saturated);
            fail_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_series_value !== want.value) begin
               $display("%0t: series_value expected %h actual %h", $time, want.value,
                        rsp_series_value);
               fail_count++;
            end
            if (rsp_saturated !== want.sat) begin
               $display("%0t: saturated expected %b actual %b", $time, want.sat,
                        rsp_saturated);
               fail_count++;
            end
         end
      end
   end

   task automatic send_item(cmd_type cmd, logic [IDX_W-1:0] idx, logic [DATA_W-1:0] value,
                            logic [DATA_W-1:0] pt);
      int unsigned gap;
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_coef_index <= idx;
      req_coef_value <= value;
      req_point <= pt;
      do @(posedge clock); while (req_stall !== 1'b0);
      if (cmd == CMD_LOAD) coef_table[idx] = value;
      else expected_results.push_back(evaluate_series(pt));
      gap = sender_idles ? pick_gap() : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_load(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] value);
      send_item(CMD_LOAD, idx, value, $urandom);
   endtask

   task automatic send_eval(logic [DATA_W-1:0] pt);
      send_item(CMD_EVAL, IDX_W'($urandom), $urandom, pt);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [DATA_W-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         REG_COEF_COUNT: cfg_count = value[COUNT_W-1:0];
         REG_MAP_SCALE:  cfg_scale = value;
         REG_MAP_OFFSET: cfg_offset = value;
         default: ;
      endcase
   endtask

   task automatic test_directed_cases();
      send_load(0, 32'h0100_0000);
      send_load(1, 32'h0080_0000);
      send_load(2, 32'hFFC0_0000);
      send_load(3, 32'h0040_0000);
      send_load(31, 32'h7FFF_FFFF);
      // single coefficient: result is c0 whatever the point
      send_eval(32'h0000_0000);
      send_eval(32'h7FFF_FFFF);
      wait_idle();
      write_reg(REG_COEF_COUNT, 0);
      send_eval(32'h8000_0000);
      wait_idle();
      write_reg(REG_COEF_COUNT, 4);
      send_eval(32'h0000_0000);
      send_eval(32'h0080_0000);
      send_eval(32'hFF00_0000);
      send_eval(32'h7FFF_FFFF);
      wait_idle();
      write_reg(REG_MAP_SCALE, 32'h7FFF_FFFF);
      send_eval(32'h7FFF_FFFF);
      wait_idle();
      write_reg(REG_MAP_SCALE, 32'h8000_0000);
      write_reg(REG_MAP_OFFSET, 32'h7FFF_FFFF);
      send_eval(32'h8000_0000);
      wait_idle();
      write_reg(REG_MAP_OFFSET, 32'h8000_0000);
      send_eval(32'h0000_0001);
      wait_idle();
      write_reg(REG_UNUSED, 32'hFFFF_FFFF);
      write_reg(REG_MAP_SCALE, SCALE_RESET);
      write_reg(REG_MAP_OFFSET, OFFSET_RESET);
      send_eval(32'h0040_0000);
      send_load(0, 32'h8000_0000);
      wait_idle();
      write_reg(REG_COEF_COUNT, 1);
      send_eval(32'h0123_4567);
      wait_idle();
   endtask

   task automatic test_load_table();
      for (int i = 0; i < MAX_COEFFS; i++)
         send_load(IDX_W'(i), $urandom_range(0, 1 << 24) - (1 << 23));
      wait_idle();
   endtask

   task automatic test_count_limits();
      write_reg(REG_COEF_COUNT, 63);
      send_eval($urandom_range(0, 1 << 25) - (1 << 24));
      send_eval($urandom_range(0, 1 << 25) - (1 << 24));
      wait_idle();
      write_reg(REG_COEF_COUNT, 33);
      send_eval($urandom_range(0, 1 << 25) - (1 << 24));
      wait_idle();
      write_reg(REG_COEF_COUNT, 32);
      send_eval($urandom_range(0, 1 << 25) - (1 << 24));
      wait_idle();
   endtask

   task automatic configure_phase(bit wild);
      int unsigned        r;
      logic [COUNT_W-1:0] count;
      r = $urandom_range(0, 99);
      if (r < 70) count = COUNT_W'($urandom_range(1, 6));
      else if (r < 90) count = COUNT_W'($urandom_range(7, 32));
      else if (r < 95) count = '0;
      else count = COUNT_W'($urandom_range(33, 63));
      write_reg(REG_COEF_COUNT, DATA_W'(count));
      write_reg(REG_MAP_SCALE,
                wild ? $urandom : (1 << 24) + $urandom_range(0, 1 << 23) - (1 << 22));
      write_reg(REG_MAP_OFFSET, wild ? $urandom : $urandom_range(0, 1 << 23) - (1 << 22));
      if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, $urandom);
   endtask

   task automatic run_phase(int unsigned items, bit wild);
      int unsigned r;
      repeat (items) begin
         r = $urandom_range(0, 99);
         if (r < 20)
            send_load(IDX_W'($urandom_range(0, MAX_COEFFS - 1)),
                      (wild || r < 2) ? $urandom : $urandom_range(0, 1 << 24) - (1 << 23));
         else
            send_eval((wild || r > 95) ? $urandom : $urandom_range(0, 1 << 25) - (1 << 24));
      end
   endtask

   task automatic test_random_phases(int unsigned phases);
      bit wild;
      repeat (phases) begin
         wild = ($urandom_range(0, 3) == 0);
         wait_idle();
         sender_idles = ($urandom_range(0, 4) != 0);
         receiver_idles = ($urandom_range(0, 4) != 0);
         configure_phase(wild);
         run_phase(PHASE_ITEMS, wild);
      end
      sender_idles = 1'b1;
      receiver_idles = 1'b1;
   endtask

   // result side held off while transfers keep coming, so the input queue fills
   task automatic test_output_backpressure();
      wait_idle();
      write_reg(REG_COEF_COUNT, 4);
      write_reg(REG_MAP_SCALE, SCALE_RESET);
      write_reg(REG_MAP_OFFSET, OFFSET_RESET);
      sender_idles = 1'b0;
      holds_asked++;
      repeat (40) send_eval($urandom_range(0, 1 << 25) - (1 << 24));
      sender_idles = 1'b1;
      wait_idle();
   endtask

   initial begin
      for (int i = 0; i < MAX_COEFFS; i++) coef_table[i] = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_load_table();
      test_count_limits();
      test_random_phases(5);
      test_output_backpressure();
      test_random_phases(6);
      wait_idle();
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
